>>> hdl/mwtg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mwtg_pkg: shared constants for the multi-waveform tone generator
// Register map, waveform codes and fixed-point constants.
// ----------------------------------------------------------------------------
package mwtg_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_WAVEFORM      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TONE_VOLUME   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MASTER_VOLUME = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_ENABLE   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_ENABLE  = 3'd7;

  localparam logic [1:0] WAVE_SINE     = 2'd0;
  localparam logic [1:0] WAVE_SQUARE   = 2'd1;
  localparam logic [1:0] WAVE_TRIANGLE = 2'd2;
  localparam logic [1:0] WAVE_SAW      = 2'd3;

  localparam int PERIOD_W = 24;
  localparam int VOLUME_W = 16;

  localparam logic [VOLUME_W-1:0] VOLUME_UNITY = 16'h8000;
  localparam logic [63:0]         ONE_Q30      = 64'h0000_0000_4000_0000;
  localparam logic [63:0]         HALF_PI_Q30  = 64'd1686629713;

endpackage
`default_nettype wire

>>> hdl/multi_waveform_tone_generator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_waveform_tone_generator_top: sine, square, triangle and sawtooth source
// One stereo sample pair per tick item with tick set, scaled by two volumes and saturated.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  in      | sink      | in_valid_i / in_stall_o    | tick_i
//  out     | source    | out_valid_o / out_stall_i  | left_sample_o, right_sample_o
//  cfg     | sink      | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
//  A tick item with tick set runs the gain, wave, ROM, value, multiply-low,
//  multiply-high and output steps, and the next item waits until it is done;
//  the one 32x32 multiplier, used four times per item, sets that sequence.
//  A tick item with tick clear is dropped in its accept cycle.
//  Reset needs no clearing pass; the sine table is constant.
//  A result held under out stall delays the item behind it in its last cycle.
// ----------------------------------------------------------------------------
module multi_waveform_tone_generator_top #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int SAMPLE_BITS      = 16,
  parameter int COUNT_BITS       = 24
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  output logic                              in_stall_o,
  input  wire                               tick_i,
  output logic                              out_valid_o,
  input  wire                               out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]     left_sample_o,
  output logic signed [SAMPLE_BITS-1:0]     right_sample_o,
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire  [mwtg_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire  [mwtg_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import mwtg_pkg::*;

  localparam int IDX_W    = $clog2(SINE_TABLE_DEPTH);
  localparam int ROM_SH   = (SAMPLE_BITS <= 31) ? 31 - SAMPLE_BITS : 0;
  localparam int ROUND_SH = (SAMPLE_BITS <= 30) ? 31 - SAMPLE_BITS : 1;
  localparam int SCALE_SH = 61 - SAMPLE_BITS;
  localparam int Q_W      = 96 - SCALE_SH;
  localparam int CMP_W    = (COUNT_BITS + 1 > PERIOD_W) ? COUNT_BITS + 1 : PERIOD_W;

  localparam logic [95:0]            SCALE_HALF = 96'd1 << (SCALE_SH - 1);
  localparam logic [SAMPLE_BITS-1:0] PMAX       = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] NMAX       = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [IDX_W-1:0]       LAST_IDX   = IDX_W'(SINE_TABLE_DEPTH - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GAIN = 3'd1;
  localparam logic [2:0] S_WAVE = 3'd2;
  localparam logic [2:0] S_ROM  = 3'd3;
  localparam logic [2:0] S_VAL  = 3'd4;
  localparam logic [2:0] S_MLO  = 3'd5;
  localparam logic [2:0] S_MHI  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  function automatic logic [SAMPLE_BITS-1:0] sine_entry(input int unsigned i);
    logic [63:0]        x;
    logic [63:0]        t;
    logic signed [63:0] s;
    logic [63:0]        r;
    logic [63:0]        maxv;
    x = (HALF_PI_Q30 * 64'(i)) / SINE_TABLE_DEPTH;
    t = x;
    s = signed'(x);
    t = (((t * x) >> 30) * x) >> 30;
    t = t / 6;
    s = s - signed'(t);
    t = (((t * x) >> 30) * x) >> 30;
    t = t / 20;
    s = s + signed'(t);
    t = (((t * x) >> 30) * x) >> 30;
    t = t / 42;
    s = s - signed'(t);
    t = (((t * x) >> 30) * x) >> 30;
    t = t / 72;
    s = s + signed'(t);
    t = (((t * x) >> 30) * x) >> 30;
    t = t / 110;
    s = s - signed'(t);
    t = (((t * x) >> 30) * x) >> 30;
    t = t / 156;
    s = s + signed'(t);
    t = (((t * x) >> 30) * x) >> 30;
    t = t / 210;
    s = s - signed'(t);
    if (s < 0) begin
      s = '0;
    end
    if (SAMPLE_BITS <= 30) begin
      r = (unsigned'(s) + (64'd1 << (ROUND_SH - 1))) >> ROUND_SH;
    end else if (SAMPLE_BITS == 31) begin
      r = unsigned'(s);
    end else begin
      r = unsigned'(s) << 1;
    end
    maxv = 64'(PMAX);
    if (r > maxv) begin
      r = maxv;
    end
    return r[SAMPLE_BITS-1:0];
  endfunction

  logic [SAMPLE_BITS-1:0] rom_w [SINE_TABLE_DEPTH];

  for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_rom
    assign rom_w[g] = sine_entry(g);
  end

  logic [1:0]             waveform_q;
  logic [31:0]            phase_step_q;
  logic [31:0]            ramp_step_q;
  logic [PERIOD_W-1:0]    period_limit_q;
  logic [VOLUME_W-1:0]    tone_volume_q;
  logic [VOLUME_W-1:0]    master_volume_q;
  logic                   left_enable_q;
  logic                   right_enable_q;

  logic [2:0]             state_q, state_d;
  logic [31:0]            phase_acc_q;
  logic [COUNT_BITS-1:0]  sample_count_q;
  logic                   neg_half_q;

  logic [31:0]            mul_a, mul_b;
  logic                   mul_en;
  logic [63:0]            p_q;
  logic [31:0]            gain_q;
  logic [63:0]            lo_q;
  logic [SAMPLE_BITS-1:0] rom_q;
  logic [63:0]            mag_q, mag_d;
  logic                   neg_q, neg_d;

  logic [IDX_W-1:0]       idx_raw, rom_addr;
  logic [63:0]            sine_mag, d_up, d_dn, ramp_mag;
  logic [CMP_W-1:0]       cnt_next;
  logic                   cnt_wrap;
  logic [95:0]            acc;
  logic [Q_W-1:0]         q;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   out_free;

  logic                         out_valid_q;
  logic signed [SAMPLE_BITS-1:0] left_q, right_q;

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b0;
    case (state_q)
      S_GAIN: begin
        mul_a  = 32'(tone_volume_q);
        mul_b  = 32'(master_volume_q);
        mul_en = 1'b1;
      end
      S_WAVE: begin
        if (waveform_q == WAVE_SINE) begin
          mul_a = {2'b00, phase_acc_q[29:0]};
          mul_b = 32'(SINE_TABLE_DEPTH);
        end else begin
          mul_a = 32'(sample_count_q);
          mul_b = ramp_step_q;
        end
        mul_en = 1'b1;
      end
      S_MLO: begin
        mul_a  = mag_q[31:0];
        mul_b  = gain_q;
        mul_en = 1'b1;
      end
      S_MHI: begin
        mul_a  = mag_q[63:32];
        mul_b  = gain_q;
        mul_en = 1'b1;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  assign idx_raw  = p_q[30 +: IDX_W];
  assign rom_addr = phase_acc_q[30] ? LAST_IDX - idx_raw : idx_raw;

  always_comb begin
    if (SAMPLE_BITS <= 31) begin
      sine_mag = 64'(rom_q) << ROM_SH;
    end else begin
      sine_mag = 64'(rom_q) >> 1;
    end
  end

  assign d_up     = p_q - ONE_Q30;
  assign d_dn     = ONE_Q30 - p_q;
  assign ramp_mag = d_up[63] ? d_dn : d_up;

  always_comb begin
    case (waveform_q)
      WAVE_SINE: begin
        mag_d = sine_mag;
        neg_d = phase_acc_q[31];
      end
      WAVE_SQUARE: begin
        mag_d = ONE_Q30;
        neg_d = neg_half_q;
      end
      WAVE_TRIANGLE: begin
        mag_d = ramp_mag;
        neg_d = neg_half_q ? d_up[63] : d_dn[63];
      end
      default: begin
        mag_d = ramp_mag;
        neg_d = d_up[63];
      end
    endcase
  end

  assign cnt_next = CMP_W'(sample_count_q) + CMP_W'(1);
  assign cnt_wrap = cnt_next > CMP_W'(period_limit_q);

  assign acc = {p_q, 32'd0} + {32'd0, lo_q} + SCALE_HALF;
  assign q   = acc[95:SCALE_SH];

  always_comb begin
    if (neg_q) begin
      sample = (q >= Q_W'(NMAX)) ? NMAX : SAMPLE_BITS'(-q[SAMPLE_BITS-1:0]);
    end else begin
      sample = (q >= Q_W'(PMAX)) ? PMAX : q[SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && tick_i) begin
          state_d = S_GAIN;
        end
      end
      S_GAIN:  state_d = S_WAVE;
      S_WAVE:  state_d = S_ROM;
      S_ROM:   state_d = S_VAL;
      S_VAL:   state_d = S_MLO;
      S_MLO:   state_d = S_MHI;
      S_MHI:   state_d = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waveform_q      <= WAVE_SINE;
      phase_step_q    <= '0;
      ramp_step_q     <= '0;
      period_limit_q  <= '0;
      tone_volume_q   <= VOLUME_UNITY;
      master_volume_q <= VOLUME_UNITY;
      left_enable_q   <= 1'b1;
      right_enable_q  <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_WAVEFORM:      waveform_q      <= cfg_data_i[1:0];
        REG_PHASE_STEP:    phase_step_q    <= cfg_data_i;
        REG_RAMP_STEP:     ramp_step_q     <= cfg_data_i;
        REG_PERIOD_LIMIT:  period_limit_q  <= cfg_data_i[PERIOD_W-1:0];
        REG_TONE_VOLUME:   tone_volume_q   <= cfg_data_i[VOLUME_W-1:0];
        REG_MASTER_VOLUME: master_volume_q <= cfg_data_i[VOLUME_W-1:0];
        REG_LEFT_ENABLE:   left_enable_q   <= cfg_data_i[0];
        REG_RIGHT_ENABLE:  right_enable_q  <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      phase_acc_q    <= '0;
      sample_count_q <= '0;
      neg_half_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_VAL) begin
        if (waveform_q == WAVE_SINE) begin
          phase_acc_q <= phase_acc_q + phase_step_q;
        end else begin
          sample_count_q <= cnt_wrap ? '0 : cnt_next[COUNT_BITS-1:0];
          if (cnt_wrap && waveform_q != WAVE_SAW) begin
            neg_half_q <= !neg_half_q;
          end
        end
      end
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      p_q <= mul_a * mul_b;
    end
    if (state_q == S_WAVE) begin
      gain_q <= p_q[31:0];
    end
    if (state_q == S_ROM) begin
      rom_q <= rom_w[rom_addr];
    end
    if (state_q == S_VAL) begin
      mag_q <= mag_d;
      neg_q <= neg_d;
    end
    if (state_q == S_MHI) begin
      lo_q <= p_q;
    end
    if (state_q == S_OUT && out_free) begin
      left_q  <= left_enable_q ? signed'(sample) : '0;
      right_q <= right_enable_q ? signed'(sample) : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign left_sample_o  = left_q;
  assign right_sample_o = right_q;

`ifndef ASSERT_OFF
  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && !(in_valid_i && tick_i)) |=> (state_q == S_IDLE))
    else $error("sequencer left idle without a tick item");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_OUT))
    else $error("result raised outside the output step");

  a_phase_only_sine: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_VAL || waveform_q != WAVE_SINE) |=> $stable(phase_acc_q))
    else $error("phase moved outside a sine update");

  a_count_not_sine: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_VAL && waveform_q == WAVE_SINE) |=>
      ($stable(sample_count_q) && $stable(neg_half_q)))
    else $error("sine update touched the counter");
`endif

endmodule
`default_nettype wire

>>> sim/multi_waveform_tone_generator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_waveform_tone_generator_top_tb: self-checking bench for the tone source
// Drives tick items through the in channel and programs all eight registers
// between phases, only while the block is idle. A cycle-free predictor of the
// sine, square, triangle and sawtooth paths works out each stereo pair. Every
// pair on the out channel is compared with it field by field. Random idle and
// stall bursts cover both handshakes.
// ----------------------------------------------------------------------------
module multi_waveform_tone_generator_top_tb;
  import mwtg_pkg::*;

  localparam int SINE_DEPTH = 1024;
  localparam int SAMPLE_W   = 16;
  localparam int COUNT_W    = 24;
  localparam int TICK_GOAL  = 1400;
  localparam int CALM_FROM  = 1150;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } stereo_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  tick_i      = 1'b0;
  logic                  out_stall_i = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_stall_o;
  logic                  out_valid_o;
  logic                  cfg_ready_o;
  logic signed [SAMPLE_W-1:0] left_sample_o;
  logic signed [SAMPLE_W-1:0] right_sample_o;

  multi_waveform_tone_generator_top #(
    .SINE_TABLE_DEPTH(SINE_DEPTH),
    .SAMPLE_BITS     (SAMPLE_W),
    .COUNT_BITS      (COUNT_W)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .tick_i        (tick_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .left_sample_o (left_sample_o),
    .right_sample_o(right_sample_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // shadow registers and generator state
  logic [1:0]          cur_wave;
  logic [31:0]         cur_phase_step;
  logic [31:0]         cur_ramp_step;
  logic [PERIOD_W-1:0] cur_period;
  logic [VOLUME_W-1:0] cur_tone;
  logic [VOLUME_W-1:0] cur_master;
  logic                cur_left_en;
  logic                cur_right_en;
  logic [31:0]         phase_acc;
  logic [COUNT_W-1:0]  sample_count;
  logic                negative_half;
  int unsigned         sine_tab [SINE_DEPTH];

  logic    pending_ticks [$];
  stereo_t awaited_samples [$];
  logic    in_taken = 1'b0;
  bit      idle_on = 1'b0;
  int      gap_left = 0;
  int      stall_left = 0;
  int      mismatches = 0;
  int      samples_checked = 0;
  int      ticks_queued = 0;
  int      settings_used = 0;

  initial begin : build_sine
    longint unsigned x, term, r;
    longint          acc;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      x = (HALF_PI_Q30 * 64'(i)) / 64'(SINE_DEPTH);
      term = x;
      acc = longint'(x);
      for (int k = 1; k <= 7; k++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) acc = acc - longint'(term);
        else acc = acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      r = (64'(acc) + 64'd16384) >> 15;
      if (r > 64'd32767) r = 64'd32767;
      sine_tab[i] = int'(r);
    end
  end

  function automatic void step_counter(input bit flips);
    logic [COUNT_W:0] nxt;
    nxt = {1'b0, sample_count} + 1'b1;
    if (nxt > {1'b0, cur_period}) begin
      sample_count = '0;
      if (flips) negative_half = ~negative_half;
    end else begin
      sample_count = nxt[COUNT_W-1:0];
    end
  endfunction

  function automatic stereo_t predict_sample();
    longint          v;
    longint unsigned ramp, gain, mag, prod, q;
    longint unsigned half;
    logic [1:0]      quad;
    int              idx;
    bit              neg;
    logic [SAMPLE_W-1:0] lvl;
    stereo_t         s;
    half = 64'd1 << 44;
    ramp = 64'(sample_count) * 64'(cur_ramp_step);
    case (cur_wave)
      WAVE_SINE: begin
        quad = phase_acc[31:30];
        idx = int'((64'(phase_acc[29:0]) * 64'(SINE_DEPTH)) >> 30);
        if (quad[0]) idx = SINE_DEPTH - 1 - idx;
        v = longint'(sine_tab[idx]) * 32768;
        if (quad[1]) v = -v;
        phase_acc = phase_acc + cur_phase_step;
      end
      WAVE_SQUARE: begin
        v = negative_half ? -longint'(ONE_Q30) : longint'(ONE_Q30);
        step_counter(1'b1);
      end
      WAVE_TRIANGLE: begin
        v = longint'(ONE_Q30) - longint'(ramp);
        if (negative_half) v = -v;
        step_counter(1'b1);
      end
      default: begin
        v = longint'(ramp) - longint'(ONE_Q30);
        step_counter(1'b0);
      end
    endcase
    gain = 64'(cur_tone) * 64'(cur_master);
    neg = (v < 0);
    mag = neg ? 64'(-v) : 64'(v);
    if (gain == 0 || mag == 0) begin
      lvl = '0;
    end else begin
      if (mag > 64'hFFFF_FFFF_FFFF_FFFF / gain) begin
        q = 64'hFFFF_FFFF_FFFF_FFFF;
      end else begin
        prod = mag * gain;
        q = (prod > 64'hFFFF_FFFF_FFFF_FFFF - half) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                     : ((prod + half) >> 45);
      end
      if (neg) lvl = (q >= 64'd32768) ? 16'h8000 : 16'(-q);
      else lvl = (q >= 64'd32767) ? 16'h7FFF : 16'(q);
    end
    s.left = cur_left_en ? lvl : '0;
    s.right = cur_right_en ? lvl : '0;
    return s;
  endfunction

  // driver: present the next tick item, with random idle bursts
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (gap_left != 0) begin
          in_valid_i <= 1'b0;
          gap_left = gap_left - 1;
        end else if (pending_ticks.size() != 0) begin
          tick_i <= pending_ticks.pop_front();
          in_valid_i <= 1'b1;
          if (idle_on && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 14);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall bursts
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left = stall_left - 1;
      end else begin
        out_stall_i <= 1'b0;
        if (idle_on && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 14);
      end
    end
  end

  // monitor: predict on accepted ticks, check accepted samples
  always @(posedge clk_i or negedge rst_ni) begin
    stereo_t exp_s;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (awaited_samples.size() == 0) begin
          $error("sample pair with none awaited: left %0d right %0d",
                 left_sample_o, right_sample_o);
          mismatches++;
        end else begin
          exp_s = awaited_samples.pop_front();
          samples_checked++;
          if (left_sample_o !== exp_s.left) begin
            $error("left_sample expected %0d got %0d", exp_s.left, left_sample_o);
            mismatches++;
          end
          if (right_sample_o !== exp_s.right) begin
            $error("right_sample expected %0d got %0d", exp_s.right, right_sample_o);
            mismatches++;
          end
        end
      end
      in_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o && tick_i) awaited_samples.push_back(predict_sample());
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_WAVEFORM:      cur_wave = data[1:0];
      REG_PHASE_STEP:    cur_phase_step = data;
      REG_RAMP_STEP:     cur_ramp_step = data;
      REG_PERIOD_LIMIT:  cur_period = data[PERIOD_W-1:0];
      REG_TONE_VOLUME:   cur_tone = data[VOLUME_W-1:0];
      REG_MASTER_VOLUME: cur_master = data[VOLUME_W-1:0];
      REG_LEFT_ENABLE:   cur_left_en = data[0];
      default:           cur_right_en = data[0];
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic queue_ticks(input int count, input bit noise);
    for (int n = 0; n < count; n++) begin
      if (noise && $urandom_range(0, 11) == 0) pending_ticks.push_back(1'b0);
      pending_ticks.push_back(1'b1);
      ticks_queued++;
    end
  endtask

  // wait until idle, then let any dropped item clear the pipeline
  task automatic drain();
    @(posedge clk_i);
    while (pending_ticks.size() != 0 || in_valid_i || awaited_samples.size() != 0)
      @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    settings_used++;
  endtask

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [1:0]          wave;
    logic [31:0]         step, ramp;
    logic [PERIOD_W-1:0] limit;
    logic [VOLUME_W-1:0] vol [2];
    cur_wave = WAVE_SINE;
    cur_phase_step = '0;
    cur_ramp_step = '0;
    cur_period = '0;
    cur_tone = VOLUME_UNITY;
    cur_master = VOLUME_UNITY;
    cur_left_en = 1'b1;
    cur_right_en = 1'b1;
    phase_acc = '0;
    sample_count = '0;
    negative_half = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset values, plus one zero tick that must be dropped
    queue_ticks(2, 1'b0);
    pending_ticks.push_back(1'b0);
    queue_ticks(1, 1'b0);
    drain();
    // quarter-turn steps visit every quadrant and wrap the phase
    write_reg(REG_PHASE_STEP, 32'h4000_0000);
    queue_ticks(5, 1'b0);
    drain();
    write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
    queue_ticks(2, 1'b0);
    drain();
    // square flipping every sample
    write_reg(REG_WAVEFORM, {30'h0, WAVE_SQUARE});
    write_reg(REG_PERIOD_LIMIT, 32'h0);
    queue_ticks(3, 1'b0);
    drain();
    // triangle with the steepest ramp saturates
    write_reg(REG_WAVEFORM, {30'h0, WAVE_TRIANGLE});
    write_reg(REG_RAMP_STEP, 32'hFFFF_FFFF);
    write_reg(REG_PERIOD_LIMIT, 32'd3);
    queue_ticks(4, 1'b0);
    drain();
    write_reg(REG_WAVEFORM, {30'h0, WAVE_SAW});
    write_reg(REG_RAMP_STEP, 32'h0800_0000);
    write_reg(REG_PERIOD_LIMIT, 32'h00FF_FFFF);
    queue_ticks(2, 1'b0);
    drain();
    // volumes above unity
    write_reg(REG_TONE_VOLUME, 32'h0000_FFFF);
    write_reg(REG_MASTER_VOLUME, 32'h0000_FFFF);
    queue_ticks(2, 1'b0);
    drain();
    write_reg(REG_TONE_VOLUME, 32'h0);
    write_reg(REG_LEFT_ENABLE, 32'h0);
    queue_ticks(1, 1'b0);
    drain();
    write_reg(REG_TONE_VOLUME, {16'h0, VOLUME_UNITY});
    write_reg(REG_LEFT_ENABLE, 32'h1);
    write_reg(REG_RIGHT_ENABLE, 32'h0);
    queue_ticks(1, 1'b0);
    drain();

    while (ticks_queued < TICK_GOAL) begin
      idle_on = (ticks_queued < CALM_FROM) && ($urandom_range(0, 9) < 7);
      wave = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 5))
        0:       step = '0;
        1:       step = '1;
        default: step = $urandom();
      endcase
      case ($urandom_range(0, 5))
        0:       limit = '0;
        1:       limit = '1;
        2:       limit = PERIOD_W'($urandom());
        default: limit = PERIOD_W'($urandom_range(1, 60));
      endcase
      case ($urandom_range(0, 5))
        0:       ramp = '0;
        1:       ramp = '1;
        2:       ramp = $urandom();
        default: ramp = 32'((64'($urandom_range(1, 4)) << 30) / (64'(limit) + 64'd1));
      endcase
      for (int j = 0; j < 2; j++) begin
        case ($urandom_range(0, 5))
          0:       vol[j] = '0;
          1:       vol[j] = '1;
          2,
          3:       vol[j] = VOLUME_UNITY;
          default: vol[j] = VOLUME_W'($urandom());
        endcase
      end
      write_reg(REG_WAVEFORM, {30'($urandom()), wave});
      write_reg(REG_PHASE_STEP, step);
      write_reg(REG_RAMP_STEP, ramp);
      write_reg(REG_PERIOD_LIMIT, {8'($urandom()), limit});
      write_reg(REG_TONE_VOLUME, {16'($urandom()), vol[0]});
      write_reg(REG_MASTER_VOLUME, {16'($urandom()), vol[1]});
      write_reg(REG_LEFT_ENABLE, {31'($urandom()), 1'($urandom_range(0, 3) != 0)});
      write_reg(REG_RIGHT_ENABLE, {31'($urandom()), 1'($urandom_range(0, 3) != 0)});
      queue_ticks($urandom_range(30, 70), 1'b1);
      drain();
    end

    $display("Checked %0d stereo sample pairs from %0d tick items", samples_checked,
             ticks_queued);
    $display("across %0d register settings of all four waveforms", settings_used);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
